[sv/gis_pkg.sv]
// Shared types and constants for the graded interval subdivision block.
// No dependencies; the divider, the top level and the testbench refer to this package by scoped names.
`default_nettype none

package gis_pkg;

	localparam int QUOT_W = 32;
	localparam int DIVR_W = 38;
	localparam int DIVD_W = QUOT_W + 33;
	localparam int RESULT_CAP = 64;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic signed [23:0] RATIO_ONE = 24'sh01_0000;
	localparam logic signed [31:0] Z_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Z_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] start_z;
		logic signed [31:0] end_z;
		logic [6:0] layer_count;
		logic signed [23:0] spacing_ratio;
		logic final_segment;
	} seg_t;

	typedef struct packed {
		logic [6:0] layer_offset;
		logic signed [31:0] z_value;
		logic last_in_segment;
		logic stack_end;
		logic overflow;
	} bnd_t;

	typedef struct packed {
		logic start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

[sv/gis_mul.sv]
// Registered 32 by 32 unsigned multiplier shared by the power and step passes.
// No dependencies.
`default_nettype none

module gis_mul (
	input wire logic clk,
	input wire logic [31:0] a,
	input wire logic [31:0] b,
	output logic [63:0] prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

[sv/gis_div.sv]
// Restoring divider, one quotient bit per cycle, with a registered quotient.
// Uses the request and response types of gis_pkg.
`default_nettype none

module gis_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire gis_pkg::div_req_t req,
	output gis_pkg::div_rsp_t rsp
);

	localparam int QW = gis_pkg::QUOT_W;
	localparam int RW = gis_pkg::DIVR_W;
	localparam int CW = $clog2(QW);

	logic [RW-1:0] rem_q;
	logic [RW-1:0] divr_q;
	logic [QW-1:0] sh_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [RW+1:0] trial;
	logic ge;

	assign trial = {1'b0, rem_q, sh_q[QW-1]} - {2'b00, divr_q};
	assign ge = !trial[RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= RW'(req.dividend[gis_pkg::DIVD_W-1:QW]);
			sh_q <= req.dividend[QW-1:0];
			divr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[RW-1:0] : {rem_q[RW-2:0], sh_q[QW-1]};
			sh_q <= {sh_q[QW-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

endmodule

`default_nettype wire

[sv/graded_interval_subdivision.sv]
// Top level: sequencer and datapath around the shared multiplier and divider.
// Depends on gis_pkg, gis_mul and gis_div.
//
// A segment item enters on seg when seg_valid and seg_ready are both high; seg_ready
// is high only while the sequencer is idle. For each segment the block sends one
// boundary item on bnd per layer, offsets 1 to n in order, the last one flagged.
// Results wait in an output register; the block keeps working on the next boundary
// while one waits and holds when both are pending and bnd_ready is low.
// Order of work, with the single multiplier and the one-bit-per-cycle divider:
// a negative ratio first has its reciprocal computed by the divider (skipped when the
// reciprocal saturates), a graded segment then computes its n - 1 power terms (start,
// multiply and accumulate per term), and each boundary before the end takes a multiply,
// the divider start, 32 divide steps and finish, the emit and, on a graded segment, the
// next power. An equal-spacing segment skips the power terms. The end boundary is set
// to the end coordinate without the divider, and the next segment is accepted once
// the end boundary has been placed in the output register.
// Reset clears the sequencer and the output valid flag; no item is in flight after it.
`default_nettype none

module graded_interval_subdivision #(
	parameter int MAX_LAYERS = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic seg_valid,
	output logic seg_ready,
	input wire gis_pkg::seg_t seg,
	output logic bnd_valid,
	input wire logic bnd_ready,
	output gis_pkg::bnd_t bnd
);

	localparam int CAP_I = (MAX_LAYERS < gis_pkg::RESULT_CAP) ? MAX_LAYERS : gis_pkg::RESULT_CAP;
	localparam logic [6:0] CAP = 7'(CAP_I);
	localparam int SW = gis_pkg::DIVR_W;
	localparam int DW = gis_pkg::DIVD_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RSTART = 4'd1;
	localparam logic [3:0] S_RWAIT = 4'd2;
	localparam logic [3:0] S_PSTART = 4'd3;
	localparam logic [3:0] S_PMUL = 4'd4;
	localparam logic [3:0] S_PACC = 4'd5;
	localparam logic [3:0] S_STEP = 4'd6;
	localparam logic [3:0] S_SMUL = 4'd7;
	localparam logic [3:0] S_DSTART = 4'd8;
	localparam logic [3:0] S_DWAIT = 4'd9;
	localparam logic [3:0] S_EMIT = 4'd10;

	logic [3:0] state_q, state_d;
	logic [6:0] cnt_q;
	logic pass2_q;
	logic bnd_valid_q;
	gis_pkg::bnd_t bnd_q;

	logic signed [31:0] s_q, e_q, z_q;
	logic [6:0] n_q;
	logic [23:0] aq_q;
	logic fin_q, neg_q, equal_q, ovf_q;
	logic [31:0] mag_q, r_q, p_q;
	logic [SW-1:0] sum_q;
	logic signed [35:0] acc_q;

	logic [6:0] n_eff;
	logic signed [32:0] dz;
	logic [31:0] mag_in;
	logic [23:0] aq_in;
	logic seg_equal, seg_neg_ratio;
	logic bnd_free, last_step;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	gis_pkg::div_req_t div_req;
	gis_pkg::div_rsp_t div_rsp;

	logic [64:0] pw_round;
	logic [31:0] pw_sat;
	logic pw_ovf;
	logic signed [35:0] acc_new;
	logic signed [36:0] zw;
	logic signed [31:0] z_sat;
	logic z_ovf;

	always_comb begin
		if (seg.layer_count == 7'd0) begin
			n_eff = 7'd1;
		end else if (seg.layer_count > CAP) begin
			n_eff = CAP;
		end else begin
			n_eff = seg.layer_count;
		end
	end

	assign dz = 33'(seg.end_z) - 33'(seg.start_z);
	assign mag_in = dz[32] ? 32'(-dz) : dz[31:0];
	assign aq_in = 24'(-seg.spacing_ratio);
	assign seg_equal = (seg.spacing_ratio == gis_pkg::RATIO_ONE);
	assign seg_neg_ratio = seg.spacing_ratio[23];
	assign bnd_free = !bnd_valid_q || bnd_ready;
	assign last_step = (cnt_q == n_q);

	always_comb begin
		mul_a = p_q;
		mul_b = r_q;
		if (state_q == S_SMUL) begin
			mul_a = mag_q;
			mul_b = equal_q ? 32'(cnt_q) : p_q;
		end
	end

	gis_mul u_mul (
		.clk (clk),
		.a (mul_a),
		.b (mul_b),
		.prod (prod)
	);

	always_comb begin
		div_req.start = (state_q == S_DSTART) || (state_q == S_RSTART && aq_q != 24'd1);
		if (state_q == S_RSTART) begin
			div_req.dividend = (DW'(1) << 32) + DW'(aq_q >> 1);
			div_req.divisor = SW'(aq_q);
		end else if (equal_q) begin
			div_req.dividend = DW'(prod) + DW'(n_q >> 1);
			div_req.divisor = SW'(n_q);
		end else begin
			div_req.dividend = DW'(prod) + DW'(sum_q >> 1);
			div_req.divisor = sum_q;
		end
	end

	gis_div u_div (
		.clk (clk),
		.arst_n (arst_n),
		.req (div_req),
		.rsp (div_rsp)
	);

	assign pw_round = DW'(prod) + 65'd32768;
	assign pw_ovf = |pw_round[64:48];
	assign pw_sat = pw_ovf ? 32'hFFFF_FFFF : pw_round[47:16];

	always_comb begin
		acc_new = neg_q ? acc_q - 36'(div_rsp.quot) : acc_q + 36'(div_rsp.quot);
		if (equal_q) begin
			zw = neg_q ? 37'(s_q) - 37'(div_rsp.quot) : 37'(s_q) + 37'(div_rsp.quot);
		end else begin
			zw = 37'(s_q) + 37'(acc_new);
		end
		z_ovf = 1'b1;
		if (zw > 37'(gis_pkg::Z_MAX)) begin
			z_sat = gis_pkg::Z_MAX;
		end else if (zw < 37'(gis_pkg::Z_MIN)) begin
			z_sat = gis_pkg::Z_MIN;
		end else begin
			z_sat = zw[31:0];
			z_ovf = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (seg_valid) begin
					state_d = seg_equal ? S_STEP : (seg_neg_ratio ? S_RSTART : S_PSTART);
				end
			end
			S_RSTART: state_d = (aq_q == 24'd1) ? S_PSTART : S_RWAIT;
			S_RWAIT: begin
				if (div_rsp.done) begin
					state_d = S_PSTART;
				end
			end
			S_PSTART: state_d = (cnt_q < n_q) ? S_PMUL : S_STEP;
			S_PMUL: state_d = S_PACC;
			S_PACC: state_d = pass2_q ? S_STEP : S_PSTART;
			S_STEP: state_d = last_step ? S_EMIT : S_SMUL;
			S_SMUL: state_d = S_DSTART;
			S_DSTART: state_d = S_DWAIT;
			S_DWAIT: begin
				if (div_rsp.done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (bnd_free) begin
					state_d = last_step ? S_IDLE : (equal_q ? S_STEP : S_PMUL);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bnd_valid_q <= 1'b0;
			cnt_q <= 7'd1;
			pass2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EMIT && bnd_free) begin
				bnd_valid_q <= 1'b1;
			end else if (bnd_ready) begin
				bnd_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE && seg_valid) begin
				cnt_q <= 7'd1;
				pass2_q <= seg_equal;
			end else if (state_q == S_PACC && !pass2_q) begin
				cnt_q <= cnt_q + 7'd1;
			end else if (state_q == S_PSTART && !(cnt_q < n_q)) begin
				cnt_q <= 7'd1;
				pass2_q <= 1'b1;
			end else if (state_q == S_EMIT && bnd_free && !last_step) begin
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (seg_valid) begin
					s_q <= seg.start_z;
					e_q <= seg.end_z;
					n_q <= n_eff;
					aq_q <= aq_in;
					fin_q <= seg.final_segment;
					mag_q <= mag_in;
					neg_q <= dz[32];
					equal_q <= seg_equal;
					r_q <= 32'(unsigned'(seg.spacing_ratio));
					p_q <= gis_pkg::ONE_Q16;
					sum_q <= SW'(gis_pkg::ONE_Q16);
					acc_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			S_RSTART: begin
				if (aq_q == 24'd1) begin
					r_q <= 32'hFFFF_FFFF;
					ovf_q <= 1'b1;
				end
			end
			S_RWAIT: begin
				if (div_rsp.done) begin
					r_q <= div_rsp.quot;
				end
			end
			S_PSTART: begin
				if (!(cnt_q < n_q)) begin
					p_q <= gis_pkg::ONE_Q16;
					acc_q <= '0;
				end
			end
			S_PACC: begin
				p_q <= pw_sat;
				if (pw_ovf) begin
					ovf_q <= 1'b1;
				end
				if (!pass2_q) begin
					sum_q <= sum_q + SW'(pw_sat);
				end
			end
			S_STEP: begin
				if (last_step) begin
					z_q <= e_q;
				end
			end
			S_DWAIT: begin
				if (div_rsp.done) begin
					z_q <= z_sat;
					if (z_ovf) begin
						ovf_q <= 1'b1;
					end
					if (!equal_q) begin
						acc_q <= acc_new;
					end
				end
			end
			S_EMIT: begin
				if (bnd_free) begin
					bnd_q.layer_offset <= cnt_q;
					bnd_q.z_value <= z_q;
					bnd_q.last_in_segment <= last_step;
					bnd_q.stack_end <= last_step && fin_q;
					bnd_q.overflow <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign seg_ready = (state_q == S_IDLE);
	assign bnd_valid = bnd_valid_q;
	assign bnd = bnd_q;

`ifndef ASSERT_OFF
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DWAIT || state_q == S_RWAIT))
		else $error("Divider finished outside a wait state.");

	a_accept_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && seg_ready) |-> !div_rsp.busy)
		else $error("Segment item accepted while a division is running.");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (cnt_q != 7'd0 && cnt_q <= n_q && n_q <= CAP))
		else $error("Boundary index out of range for the segment.");

	a_end_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && bnd_free && last_step) |=> (bnd.z_value == $past(e_q)))
		else $error("Segment end boundary does not equal the end coordinate.");
`endif

endmodule

`default_nettype wire

[test/tb_graded_interval_subdivision.sv]
// Testbench for graded_interval_subdivision: sends segment items and checks every boundary
// item against a predictor built into this file, under varying idle and stall patterns.
// Depends on gis_pkg and the graded_interval_subdivision RTL.
`timescale 1ns / 100ps

module tb_graded_interval_subdivision;

	localparam int MAX_LAYERS = 64;
	localparam logic [63:0] UNIT_Q16 = 64'h1_0000;
	localparam logic [63:0] POWER_SAT = 64'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;
	logic seg_valid;
	logic seg_ready;
	gis_pkg::seg_t seg;
	logic bnd_valid;
	logic bnd_ready;
	gis_pkg::bnd_t bnd;

	gis_pkg::bnd_t expected_bounds[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_len = 0;

	graded_interval_subdivision #(
		.MAX_LAYERS(MAX_LAYERS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg_valid(seg_valid),
		.seg_ready(seg_ready),
		.seg(seg),
		.bnd_valid(bnd_valid),
		.bnd_ready(bnd_ready),
		.bnd(bnd)
	);

	always #10 clk = ~clk;

	task automatic grade_segment(input gis_pkg::seg_t item);
		longint seg_start, seg_end, span, acc, z;
		longint ratio;
		int unsigned layers, i, k;
		logic [63:0] mag, r, sum, term, step, off, abs_ratio;
		logic [63:0] powers [gis_pkg::RESULT_CAP];
		bit neg, ovf, equal;
		gis_pkg::bnd_t b;
		seg_start = item.start_z;
		seg_end = item.end_z;
		ratio = item.spacing_ratio;
		layers = item.layer_count;
		if (layers == 0)
			layers = 1;
		if (layers > MAX_LAYERS)
			layers = MAX_LAYERS;
		if (layers > gis_pkg::RESULT_CAP)
			layers = gis_pkg::RESULT_CAP;
		span = seg_end - seg_start;
		neg = span < 0;
		mag = neg ? 64'(-span) : 64'(span);
		equal = (item.spacing_ratio == gis_pkg::RATIO_ONE);
		ovf = 1'b0;
		acc = 0;
		r = '0;
		sum = UNIT_Q16;
		powers[0] = UNIT_Q16;
		if (!equal) begin
			if (ratio >= 0) begin
				r = 64'(ratio);
			end else begin
				abs_ratio = 64'(-ratio);
				r = ((64'd1 << 32) + abs_ratio / 2) / abs_ratio;
				if (r > POWER_SAT) begin
					r = POWER_SAT;
					ovf = 1'b1;
				end
			end
			for (k = 1; k < layers; k++) begin
				term = (powers[k - 1] * r + 64'd32768) >> 16;
				if (term > POWER_SAT) begin
					term = POWER_SAT;
					ovf = 1'b1;
				end
				powers[k] = term;
				sum += term;
			end
		end
		for (i = 1; i <= layers; i++) begin
			if (i == layers) begin
				z = seg_end;
			end else if (equal) begin
				off = (mag * 64'(i) + 64'(layers / 2)) / 64'(layers);
				z = neg ? seg_start - longint'(off) : seg_start + longint'(off);
			end else begin
				step = (mag * powers[i - 1] + sum / 2) / sum;
				acc = neg ? acc - longint'(step) : acc + longint'(step);
				z = seg_start + acc;
			end
			if (z > longint'(gis_pkg::Z_MAX)) begin
				z = gis_pkg::Z_MAX;
				ovf = 1'b1;
			end
			if (z < longint'(gis_pkg::Z_MIN)) begin
				z = gis_pkg::Z_MIN;
				ovf = 1'b1;
			end
			b.layer_offset = 7'(i);
			b.z_value = z[31:0];
			b.last_in_segment = (i == layers);
			b.stack_end = (i == layers) && item.final_segment;
			b.overflow = ovf;
			expected_bounds = {expected_bounds, b};
		end
	endtask

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $time, what);
	endtask

	always @(posedge clk) begin : check_boundary
		gis_pkg::bnd_t want;
		if (arst_n && bnd_valid && bnd_ready) begin
			if (expected_bounds.size() == 0) begin
				flag_mismatch($sformatf("unexpected item: offset %0d z %0d last %b end %b ovf %b",
					bnd.layer_offset, bnd.z_value, bnd.last_in_segment, bnd.stack_end,
					bnd.overflow));
			end else begin
				want = expected_bounds.pop_front();
				if (bnd.layer_offset !== want.layer_offset || bnd.z_value !== want.z_value ||
						bnd.last_in_segment !== want.last_in_segment ||
						bnd.stack_end !== want.stack_end || bnd.overflow !== want.overflow)
					flag_mismatch($sformatf(
						"expected offset %0d z %0d last %b end %b ovf %b, got %0d %0d %b %b %b",
						want.layer_offset, want.z_value, want.last_in_segment, want.stack_end,
						want.overflow, bnd.layer_offset, bnd.z_value, bnd.last_in_segment,
						bnd.stack_end, bnd.overflow));
			end
		end
	end

	initial begin : receiver
		bnd_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				bnd_ready <= 1'b0;
				repeat (hold_off_len) @(posedge clk);
				hold_off_len = 0;
			end
			bnd_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_segment(input gis_pkg::seg_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			seg_valid <= 1'b0;
			@(posedge clk);
		end
		seg <= item;
		seg_valid <= 1'b1;
		@(posedge clk);
		while (!seg_ready)
			@(posedge clk);
		grade_segment(item);
	endtask

	task automatic wait_all_boundaries();
		seg_valid <= 1'b0;
		while (expected_bounds.size() != 0)
			@(posedge clk);
	endtask

	function automatic gis_pkg::seg_t make_segment(input longint start_z, input longint end_z,
			input int layers, input int ratio, input bit fin);
		gis_pkg::seg_t item;
		item.start_z = start_z[31:0];
		item.end_z = end_z[31:0];
		item.layer_count = 7'(layers);
		item.spacing_ratio = 24'(ratio);
		item.final_segment = fin;
		return item;
	endfunction

	function automatic gis_pkg::seg_t random_segment();
		gis_pkg::seg_t item;
		int pick;
		if ($urandom_range(3) == 0)
			item.start_z = $urandom;
		else
			item.start_z = $urandom_range(32'h0100_0000) - 32'h0080_0000;
		pick = $urandom_range(99);
		if (pick < 30)
			item.end_z = $urandom;
		else if (pick < 35)
			item.end_z = item.start_z;
		else
			item.end_z = item.start_z + ($urandom_range(32'h0080_0000) - 32'h0040_0000);
		pick = $urandom_range(99);
		if (pick < 75)
			item.layer_count = 7'($urandom_range(1, 8));
		else if (pick < 90)
			item.layer_count = 7'($urandom_range(9, 63));
		else if (pick < 95)
			item.layer_count = 7'(MAX_LAYERS);
		else
			item.layer_count = 7'($urandom_range(127));
		pick = $urandom_range(99);
		if (pick < 20)
			item.spacing_ratio = gis_pkg::RATIO_ONE;
		else if (pick < 28)
			item.spacing_ratio = -gis_pkg::RATIO_ONE;
		else if (pick < 34)
			item.spacing_ratio = '0;
		else if (pick < 64)
			item.spacing_ratio = 24'($urandom_range(32'h4_0000));
		else if (pick < 88)
			item.spacing_ratio = 24'(-int'($urandom_range(1, 32'h4_0000)));
		else
			item.spacing_ratio = 24'($urandom);
		item.final_segment = 1'($urandom_range(1));
		return item;
	endfunction

	task automatic test_directed_cases();
		longint zmax, zmin;
		int one;
		zmax = gis_pkg::Z_MAX;
		zmin = gis_pkg::Z_MIN;
		one = gis_pkg::RATIO_ONE;
		send_segment(make_segment(0, 10 << 16, 4, one, 1'b0));
		send_segment(make_segment(5 << 16, -(3 << 16), 1, one, 1'b1));
		send_segment(make_segment(-(2 << 16), 7 << 16, 5, -one, 1'b0));
		send_segment(make_segment(100, 100 << 16, 6, 0, 1'b1));
		send_segment(make_segment(0, 1000 << 16, 3, -1, 1'b0));
		send_segment(make_segment(0, 1000 << 16, 4, -2, 1'b0));
		send_segment(make_segment(0, 50 << 16, 8, 8388607, 1'b0));
		send_segment(make_segment(0, 50 << 16, 8, -8388608, 1'b1));
		send_segment(make_segment(zmin, zmax, 64, one, 1'b0));
		send_segment(make_segment(zmax, zmin, 12, 2 * one, 1'b1));
		send_segment(make_segment(0, 3 << 16, 0, one - 1, 1'b0));
		send_segment(make_segment(0, -(3 << 16), 127, one + 1, 1'b1));
		send_segment(make_segment(1, 2, 65, 3 * one, 1'b0));
		send_segment(make_segment(zmax - 96, zmax, 64, -one, 1'b0));
		send_segment(make_segment(zmin + 96, zmin, 64, -one, 1'b1));
		send_segment(make_segment(-1, -1, 7, one / 2, 1'b0));
		send_segment(make_segment(zmin, zmax, 16, -8388607, 1'b0));
		send_segment(make_segment(-(40 << 16), 40 << 16, 10, 3 * one / 2, 1'b1));
		send_segment(make_segment(0, -(7 << 16), 9, -(3 * one / 2), 1'b0));
		wait_all_boundaries();
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_segment(random_segment());
		wait_all_boundaries();
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_len = 2000;
		repeat (8)
			send_segment(make_segment(0, 12 << 16, 4, 2 * gis_pkg::RATIO_ONE, 1'b0));
		wait_all_boundaries();
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 0;
		recv_stall_pct = 23;
		repeat (5)
			send_segment(random_segment());
		wait_all_boundaries();
		repeat (5)
			send_segment(random_segment());
		wait_all_boundaries();
	endtask

	initial begin
		arst_n = 1'b0;
		seg_valid <= 1'b0;
		seg <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic(105, 0, 0);
		test_random_traffic(105, 79, 0);
		test_random_traffic(105, 0, 79);
		test_random_traffic(105, 23, 23);
		test_output_backpressure();
		test_drain_pause();
		wait_all_boundaries();
		repeat (3000) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_graded_interval_subdivision passed");
		else
			$display("tb_graded_interval_subdivision failed");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("tb_graded_interval_subdivision failed");
		$finish;
	end

endmodule

[sim.f]
sv/gis_pkg.sv
sv/gis_mul.sv
sv/gis_div.sv
sv/graded_interval_subdivision.sv
test/tb_graded_interval_subdivision.sv
